// ===== hw/rtl/dq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, command codes, ring index arithmetic and the ring store
// access bundle for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH = 16;
	localparam int DW    = 32;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [2:0] OP_POP_BACK   = 3'd2;
	localparam logic [2:0] OP_POP_FRONT  = 3'd3;
	localparam logic [2:0] OP_SEARCH     = 3'd4;

	localparam logic [DW-1:0] NEG_ONE = '1;

	typedef logic [AW-1:0] idx_t;
	typedef logic [CW-1:0] cnt_t;
	typedef logic [DW-1:0] word_t;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		word_t wdata;
		idx_t  raddr_a;
		idx_t  raddr_b;
	} ram_req_t;

	// ring position base + off, off no larger than DEPTH
	function automatic idx_t ring_add(input idx_t base, input cnt_t off);
		logic [AW:0] sum;
		sum = (AW+1)'(base) + (AW+1)'(off);
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	function automatic idx_t ring_dec(input idx_t base);
		idx_t r;
		if (base == '0) begin
			r = AW'(DEPTH - 1);
		end else begin
			r = base - AW'(1);
		end
		return r;
	endfunction

endpackage : dq_pkg
`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values kept in a ring store.
// ----------------------------------------------------------------------------
// Commands are taken one at a time and in_stall stays high until the command
// is finished. Every command passes through ST_ENDS and ST_WAIT; a pop of a
// filled queue goes through ST_POP first and a search through ST_SEARCH, where
// read port a walks the filled entries one per cycle through one comparator.
// Every command ends by reading the front and back entries, so each result
// carries the queue's ends after that command.
// A push to a full queue is dropped and flagged; a pop of an empty queue
// returns -1 and is flagged. The result register holds its transfer while
// the next command is already being worked on.
module double_ended_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [2:0]             op,
	input  wire logic signed [31:0]     value,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic signed [31:0]          popped_value,
	output logic                        found,
	output logic                        error,
	output logic                        empty_res,
	output logic signed [31:0]          front_value,
	output logic signed [31:0]          back_value
);
	import dq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_SEARCH,
		ST_ENDS,
		ST_WAIT
	} state_t;

	state_t   state_q;
	idx_t     front_q;
	cnt_t     count_q;
	cnt_t     idx_q;
	logic     cmp_v_q;
	word_t    val_q;
	word_t    popped_q;
	logic     found_q;
	logic     err_q;
	ram_req_t req;
	word_t    rd_a;
	word_t    rd_b;

	logic in_xfer;
	logic out_free;
	logic out_load;
	logic full;
	logic empty;
	logic issuing;
	idx_t back_idx;
	idx_t front_dec;

	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign out_load  = (state_q == ST_WAIT) && out_free;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign issuing   = (idx_q < count_q);
	assign back_idx  = ring_add(front_q, count_q - CW'(1));
	assign front_dec = ring_dec(front_q);
	assign in_stall  = (state_q != ST_IDLE);

	always_comb begin
		req         = '0;
		req.wdata   = value;
		req.raddr_a = (op == OP_POP_BACK) ? back_idx : front_q;
		req.raddr_b = back_idx;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && !full) begin
					if (op == OP_PUSH_BACK) begin
						req.we    = 1'b1;
						req.waddr = ring_add(front_q, count_q);
					end else if (op == OP_PUSH_FRONT) begin
						req.we    = 1'b1;
						req.waddr = front_dec;
					end
				end
			end
			ST_SEARCH: begin
				req.raddr_a = ring_add(front_q, idx_q);
			end
			default: begin
				req.raddr_a = front_q;
			end
		endcase
	end

	dq_ring_ram u_ram (
		.clk  (clk),
		.req  (req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			front_q      <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			cmp_v_q      <= 1'b0;
			out_valid    <= 1'b0;
			val_q        <= '0;
			popped_q     <= '0;
			found_q      <= 1'b0;
			err_q        <= 1'b0;
			popped_value <= '0;
			found        <= 1'b0;
			error        <= 1'b0;
			empty_res    <= 1'b1;
			front_value  <= '0;
			back_value   <= '0;
		end else begin
			if (out_valid && !out_stall && !out_load) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						val_q    <= value;
						popped_q <= '0;
						found_q  <= 1'b0;
						err_q    <= 1'b0;
						idx_q    <= '0;
						cmp_v_q  <= 1'b0;
						state_q  <= ST_ENDS;
						case (op)
							OP_PUSH_BACK: begin
								if (full) begin
									err_q <= 1'b1;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							OP_PUSH_FRONT: begin
								if (full) begin
									err_q <= 1'b1;
								end else begin
									front_q <= front_dec;
									count_q <= count_q + CW'(1);
								end
							end
							OP_POP_BACK, OP_POP_FRONT: begin
								if (empty) begin
									popped_q <= NEG_ONE;
									err_q    <= 1'b1;
								end else begin
									// entry is read this cycle from the old position
									if (op == OP_POP_FRONT) begin
										front_q <= ring_add(front_q, CW'(1));
									end
									count_q <= count_q - CW'(1);
									state_q <= ST_POP;
								end
							end
							OP_SEARCH: begin
								state_q <= ST_SEARCH;
							end
							default: begin
							end
						endcase
					end
				end
				ST_POP: begin
					popped_q <= rd_a;
					state_q  <= ST_ENDS;
				end
				ST_SEARCH: begin
					// one read issued and one compare made per cycle
					if (cmp_v_q && (rd_a == val_q)) begin
						found_q <= 1'b1;
					end
					cmp_v_q <= issuing;
					if (issuing) begin
						idx_q <= idx_q + CW'(1);
					end else if (!cmp_v_q) begin
						state_q <= ST_ENDS;
					end
				end
				ST_ENDS: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						popped_value <= popped_q;
						found        <= found_q;
						error        <= err_q;
						empty_res    <= empty;
						front_value  <= empty ? NEG_ONE : rd_a;
						back_value   <= empty ? NEG_ONE : rd_b;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule : double_ended_queue
`default_nettype wire

// ===== hw/rtl/dq_ring_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ring_ram
// Ring store of the queue: one write port and two read ports, read data
// registered.
// ----------------------------------------------------------------------------
module dq_ring_ram (
	input  wire logic             clk,
	input  wire dq_pkg::ram_req_t req,
	output dq_pkg::word_t         rd_a,
	output dq_pkg::word_t         rd_b
);
	import dq_pkg::*;

	word_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_a <= mem_q[req.raddr_a];
		rd_b <= mem_q[req.raddr_b];
	end

endmodule : dq_ring_ram
`default_nettype wire

// ===== dv/deque_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches both channels of the double-ended queue. Each accepted command
// runs through a local copy of the queue, and the answer it gives is held
// until the matching result transfer arrives. That result is then compared
// field by field.
// ----------------------------------------------------------------------------
module deque_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [2:0]            op,
	input  logic [dq_pkg::DW-1:0] value,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [dq_pkg::DW-1:0] popped_value,
	input  logic                  found,
	input  logic                  error,
	input  logic                  empty_res,
	input  logic [dq_pkg::DW-1:0] front_value,
	input  logic [dq_pkg::DW-1:0] back_value,
	output int unsigned           failures,
	output int unsigned           outstanding
);
	import dq_pkg::*;

	typedef struct packed {
		logic [DW-1:0] popped;
		logic          hit;
		logic          err;
		logic          empty;
		logic [DW-1:0] front;
		logic [DW-1:0] back;
	} deque_result_t;

	logic [DW-1:0] slots [DEPTH];
	int            head_pos;
	int            fill_level;
	deque_result_t results_due [$];

	function automatic int ring_at(input int offset);
		return (head_pos + offset) % DEPTH;
	endfunction

	// updates the local queue and returns the answer for one command
	function automatic deque_result_t apply_command(input logic [2:0] cmd,
			input logic [DW-1:0] v);
		deque_result_t r;
		r = '0;
		case (cmd)
			OP_PUSH_BACK: begin
				if (fill_level == DEPTH) begin
					r.err = 1'b1;
				end else begin
					slots[ring_at(fill_level)] = v;
					fill_level++;
				end
			end
			OP_PUSH_FRONT: begin
				if (fill_level == DEPTH) begin
					r.err = 1'b1;
				end else begin
					head_pos = ring_at(DEPTH - 1);
					slots[head_pos] = v;
					fill_level++;
				end
			end
			OP_POP_BACK: begin
				if (fill_level == 0) begin
					r.popped = NEG_ONE;
					r.err    = 1'b1;
				end else begin
					r.popped = slots[ring_at(fill_level - 1)];
					fill_level--;
				end
			end
			OP_POP_FRONT: begin
				if (fill_level == 0) begin
					r.popped = NEG_ONE;
					r.err    = 1'b1;
				end else begin
					r.popped = slots[head_pos];
					head_pos = ring_at(1);
					fill_level--;
				end
			end
			OP_SEARCH: begin
				for (int i = 0; i < fill_level; i++) begin
					if (slots[ring_at(i)] == v) begin
						r.hit = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		// head position is kept when a pop empties the queue
		if (fill_level == 0) begin
			r.empty = 1'b1;
			r.front = NEG_ONE;
			r.back  = NEG_ONE;
		end else begin
			r.front = slots[head_pos];
			r.back  = slots[ring_at(fill_level - 1)];
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [DW-1:0] want,
			input logic [DW-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, $signed(want),
				$signed(got));
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		deque_result_t want;
		if (!arst_n) begin
			head_pos   = 0;
			fill_level = 0;
			results_due.delete();
			outstanding = 0;
		end else begin
			// a result always belongs to an earlier command, so check first
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("result transfer with no command waiting for it");
					failures++;
				end else begin
					want = results_due[0];
					results_due.delete(0);
					check_field("popped_value", want.popped, popped_value);
					check_field("found", DW'(want.hit), DW'(found));
					check_field("error", DW'(want.err), DW'(error));
					check_field("empty_res", DW'(want.empty), DW'(empty_res));
					check_field("front_value", want.front, front_value);
					check_field("back_value", want.back, back_value);
				end
			end
			if (in_valid && !in_stall) begin
				results_due.insert(results_due.size(), apply_command(op, value));
			end
			outstanding = results_due.size();
		end
	end

endmodule

// ===== dv/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Drives commands into the double-ended queue: a directed opening on the
// empty and edge cases, then push-heavy, pop-heavy and mixed runs that take the
// queue to full and back to empty, with random gaps on both sides, a stretch
// without gaps and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
	import dq_pkg::*;

	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	localparam int RANDOM_CMDS = 1150;
	localparam int HOLD_CYCLES = 300;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	logic [2:0]    op;
	logic [DW-1:0] value;
	logic          out_valid;
	logic          out_stall;
	logic [DW-1:0] popped_value;
	logic          found;
	logic          error;
	logic          empty_res;
	logic [DW-1:0] front_value;
	logic [DW-1:0] back_value;
	int unsigned   failures;
	int unsigned   outstanding;

	logic          gaps_on;
	logic          hold_req;
	int            cmds_sent;
	logic [DW-1:0] value_pool [8];

	double_ended_queue i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.popped_value (popped_value),
		.found        (found),
		.error        (error),
		.empty_res    (empty_res),
		.front_value  (front_value),
		.back_value   (back_value)
	);

	deque_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.popped_value (popped_value),
		.found        (found),
		.error        (error),
		.empty_res    (empty_res),
		.front_value  (front_value),
		.back_value   (back_value),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_command(input logic [2:0] cmd, input logic [DW-1:0] v);
		while (gaps_on && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			op       <= 3'($urandom());
			value    <= $urandom();
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= cmd;
		value    <= v;
		do begin
			@(posedge clk);
		end while (in_stall);
		@(negedge clk);
		cmds_sent++;
	endtask

	// a small pool makes searches hit and repeats values in the ring
	function automatic logic [DW-1:0] pick_value();
		if ($urandom_range(99) < 55) begin
			return value_pool[$urandom_range(7)];
		end
		return $urandom();
	endfunction

	function automatic logic [2:0] pick_spare();
		case ($urandom_range(2))
			0: return OP_SPARE_5;
			1: return OP_SPARE_6;
			default: return OP_SPARE_7;
		endcase
	endfunction

	// run kinds: 0 fills the queue, 1 drains it, 2 mixes everything
	function automatic logic [2:0] pick_op(input int kind);
		int r;
		r = $urandom_range(99);
		if (r >= 97) begin
			return pick_spare();
		end
		if (kind == 2) begin
			case (r % 5)
				0: return OP_PUSH_BACK;
				1: return OP_PUSH_FRONT;
				2: return OP_POP_BACK;
				3: return OP_POP_FRONT;
				default: return OP_SEARCH;
			endcase
		end
		if (r < 78) begin
			if (kind == 0) begin
				return r[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
			end
			return r[0] ? OP_POP_FRONT : OP_POP_BACK;
		end
		if (r < 83) begin
			if (kind == 0) begin
				return r[0] ? OP_POP_FRONT : OP_POP_BACK;
			end
			return r[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
		end
		return OP_SEARCH;
	endfunction

	// result side: random stalls, plus one long hold-off on request
	initial begin : responder
		bit held;
		held = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
			end
			out_stall <= gaps_on && ($urandom_range(99) < 37);
		end
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int kind;
		int run_len;
		bit hold_done;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		op        = OP_PUSH_BACK;
		value     = '0;
		gaps_on   = 1'b1;
		hold_req  = 1'b0;
		hold_done = 1'b0;
		cmds_sent = 0;
		value_pool[0] = 32'h7fff_ffff;
		value_pool[1] = 32'h8000_0000;
		value_pool[2] = '0;
		value_pool[3] = NEG_ONE;
		value_pool[4] = 32'd1;
		for (int i = 5; i < 8; i++) begin
			value_pool[i] = $urandom();
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty queue: pops fail, search misses, spare codes leave it alone
		send_command(OP_POP_BACK, 32'd5);
		send_command(OP_POP_FRONT, 32'd6);
		send_command(OP_SEARCH, NEG_ONE);
		send_command(OP_SPARE_5, 32'd7);
		send_command(OP_PUSH_BACK, 32'h7fff_ffff);
		send_command(OP_PUSH_FRONT, 32'h8000_0000);
		send_command(OP_PUSH_BACK, '0);
		send_command(OP_PUSH_FRONT, NEG_ONE);
		send_command(OP_SEARCH, NEG_ONE);
		send_command(OP_SEARCH, 32'h7fff_ffff);
		send_command(OP_SEARCH, 32'd12345);
		send_command(OP_SPARE_6, 32'h8000_0000);
		send_command(OP_SPARE_7, NEG_ONE);
		send_command(OP_POP_FRONT, '0);
		send_command(OP_POP_BACK, '0);
		send_command(OP_POP_FRONT, '0);
		send_command(OP_POP_BACK, '0);
		// emptied by pops: head position stays where it was
		send_command(OP_POP_BACK, '0);
		send_command(OP_SEARCH, '0);
		send_command(OP_PUSH_BACK, 32'h5a5a_a5a5);
		send_command(OP_SEARCH, 32'h5a5a_a5a5);
		send_command(OP_POP_FRONT, '0);

		while (cmds_sent < RANDOM_CMDS + 22) begin
			kind    = $urandom_range(2);
			run_len = $urandom_range(10, 45);
			gaps_on = !(cmds_sent > 400 && cmds_sent < 600);
			if (!hold_done && cmds_sent > 800) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			repeat (run_len) send_command(pick_op(kind), pick_value());
		end
		in_valid <= 1'b0;

		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (40) @(negedge clk);
		if (failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/dq_pkg.sv
hw/rtl/dq_ring_ram.sv
hw/rtl/double_ended_queue.sv
dv/deque_checker.sv
dv/tb_double_ended_queue.sv
